@@ rtl/tdsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Tagged delta stream decoder package
// Parse phase codes, record tags, header constants and the step result type.
// ----------------------------------------------------------------------------
package tdsd_pkg;

    localparam int LIMIT_W = 20;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd100000;

    localparam logic [3:0] HEADER_LEN = 4'd12;
    localparam logic [3:0] MAGIC_LEN  = 4'd4;
    localparam logic [3:0] COUNT_POS  = 4'd8;

    // Parse phases
    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_TAG      = 3'd1;
    localparam logic [2:0] PH_LOAD     = 3'd2;
    localparam logic [2:0] PH_DELTA    = 3'd3;
    localparam logic [2:0] PH_RUN      = 3'd4;
    localparam logic [2:0] PH_STOP     = 3'd5;
    localparam logic [2:0] PH_BADMAGIC = 3'd6;
    localparam logic [2:0] PH_LIMIT    = 3'd7;

    // Record tags
    localparam logic [7:0] TAG_LOAD  = 8'd0;
    localparam logic [7:0] TAG_DELTA = 8'd1;
    localparam logic [7:0] TAG_RUN   = 8'd2;
    localparam logic [7:0] TAG_CLEAR = 8'd3;

    // End-of-message status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_HEADER = 2'd1;
    localparam logic [1:0] ST_LIMIT  = 2'd2;

    // Result kinds
    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Results caused by one input byte: an optional value run, then an
    // optional end-of-message status.
    typedef struct packed {
        logic        val_v;
        logic [31:0] val;
        logic [7:0]  rep;
        logic        end_v;
        logic [1:0]  st;
    } step_t;

    // The magic "IDLT", one byte at a time.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h49;
            2'd1:    b = 8'h44;
            2'd2:    b = 8'h4C;
            2'd3:    b = 8'h54;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/tdsd_core.sv @@
// ----------------------------------------------------------------------------
// Tagged delta stream decoder core
// Holds the parse state and the count limit, and works out in one pass the
// results and the next state for the byte on its input.
// ----------------------------------------------------------------------------
module tdsd_core #(
    parameter int COUNT_BITS = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_buffer,
    input  logic                        cfg_we,
    input  logic [tdsd_pkg::LIMIT_W-1:0] cfg_wdata,
    output tdsd_pkg::step_t             step,
    output logic [COUNT_BITS-1:0]       total
);
    import tdsd_pkg::*;

    logic [LIMIT_W-1:0]    limit_reg;
    logic [3:0]            hpos_reg, hpos_next;
    logic                  mism_reg, mism_next;
    logic [31:0]           dcount_reg, dcount_next;
    logic [31:0]           acc_reg, acc_next;
    logic [COUNT_BITS-1:0] ecount_reg, ecount_next;
    logic [2:0]            phase_reg, phase_next;
    logic [1:0]            obi_reg, obi_next;
    logic [31:0]           opnd_reg, opnd_next;

    logic        emit_req;
    logic [7:0]  run_len;
    logic [31:0] left;
    logic [7:0]  rep;

    always_comb
    begin
        hpos_next   = hpos_reg;
        mism_next   = mism_reg;
        dcount_next = dcount_reg;
        acc_next    = acc_reg;
        ecount_next = ecount_reg;
        phase_next  = phase_reg;
        obi_next    = obi_reg;
        opnd_next   = opnd_reg;
        emit_req    = 1'b0;
        run_len     = 8'd0;
        step        = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (hpos_reg < MAGIC_LEN) begin
                    if (data_byte != magic_byte(hpos_reg[1:0]))
                        mism_next = 1'b1;
                end else if (hpos_reg >= COUNT_POS) begin
                    dcount_next[{hpos_reg[1:0], 3'b000} +: 8] =
                        dcount_reg[{hpos_reg[1:0], 3'b000} +: 8] | data_byte;
                end
                hpos_next = hpos_reg + 4'd1;
                if (hpos_next >= HEADER_LEN) begin
                    if (mism_next)
                        phase_next = PH_BADMAGIC;
                    else if (dcount_next > 32'(limit_reg))
                        phase_next = PH_LIMIT;
                    else if (dcount_next == 32'd0)
                        phase_next = PH_STOP;
                    else
                        phase_next = PH_TAG;
                end
            end
            PH_TAG:
            begin
                obi_next  = 2'd0;
                opnd_next = 32'd0;
                case (data_byte)
                    TAG_LOAD:  phase_next = PH_LOAD;
                    TAG_DELTA: phase_next = PH_DELTA;
                    TAG_RUN:   phase_next = PH_RUN;
                    TAG_CLEAR: acc_next   = 32'd0;
                    default:   phase_next = PH_STOP;
                endcase
            end
            PH_LOAD, PH_DELTA:
            begin
                opnd_next[{obi_reg, 3'b000} +: 8] =
                    opnd_reg[{obi_reg, 3'b000} +: 8] | data_byte;
                obi_next = obi_reg + 2'd1;
                if (phase_reg == PH_LOAD && obi_next == 2'd0) begin
                    acc_next = opnd_next;
                    emit_req = 1'b1;
                    run_len  = 8'd1;
                end else if (phase_reg == PH_DELTA && obi_next == 2'd2) begin
                    acc_next = acc_reg + {{16{opnd_next[15]}}, opnd_next[15:0]};
                    emit_req = 1'b1;
                    run_len  = 8'd1;
                end
            end
            PH_RUN:
            begin
                emit_req = 1'b1;
                run_len  = data_byte;
            end
            default:
            begin
            end
        endcase

        // A run is cut so that the emitted total never passes the declared count.
        left = dcount_reg - 32'(ecount_reg);
        rep  = (32'(run_len) < left) ? run_len : left[7:0];
        if (emit_req && rep != 8'd0) begin
            ecount_next = ecount_reg + COUNT_BITS'(rep);
            step.val_v  = 1'b1;
            step.val    = acc_next;
            step.rep    = rep;
            if (32'(ecount_next) >= dcount_reg)
                phase_next = PH_STOP;
            else
                phase_next = PH_TAG;
        end
        if (phase_reg == PH_RUN && phase_next == PH_RUN)
            phase_next = PH_TAG;

        total = ecount_next;

        if (end_of_buffer) begin
            step.end_v = 1'b1;
            if (phase_next == PH_HEADER || phase_next == PH_BADMAGIC)
                step.st = ST_HEADER;
            else if (phase_next == PH_LIMIT)
                step.st = ST_LIMIT;
            else
                step.st = ST_OK;
            hpos_next   = 4'd0;
            mism_next   = 1'b0;
            dcount_next = 32'd0;
            acc_next    = 32'd0;
            ecount_next = '0;
            phase_next  = PH_HEADER;
            obi_next    = 2'd0;
            opnd_next   = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_reg  <= LIMIT_RESET;
            hpos_reg   <= 4'd0;
            mism_reg   <= 1'b0;
            dcount_reg <= 32'd0;
            acc_reg    <= 32'd0;
            ecount_reg <= '0;
            phase_reg  <= PH_HEADER;
            obi_reg    <= 2'd0;
            opnd_reg   <= 32'd0;
        end else begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            if (accept) begin
                hpos_reg   <= hpos_next;
                mism_reg   <= mism_next;
                dcount_reg <= dcount_next;
                acc_reg    <= acc_next;
                ecount_reg <= ecount_next;
                phase_reg  <= phase_next;
                obi_reg    <= obi_next;
                opnd_reg   <= opnd_next;
            end
        end
    end

endmodule

@@ rtl/tagged_delta_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// Tagged delta stream decoder
// Checks a 12-byte header, then decodes tagged load, delta, run and clear
// records into value runs, and closes each message with a status beat.
//
//   channel   direction  handshake            payload
//   input     in         in_valid/in_ready    data_byte, end_of_buffer
//   output    out        out_valid/out_ready  kind, value, repeat_res, status,
//                                             total_emitted, last_of_run
//   config    in         cfg_we               cfg_wdata (count limit)
//
// One input byte is taken per cycle while the input is ready; its results land
// in a two-slot result register on the next edge. A byte that causes a value
// run and an end status holds the input off until the value beat has left. The
// input is ready whenever the result slots are empty or their last beat leaves
// in that cycle. Reset clears the parse state and sets the limit to 100000.
// ----------------------------------------------------------------------------
module tagged_delta_stream_decoder #(
    parameter int COUNT_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         end_of_buffer,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         kind,
    output logic signed [31:0]           value,
    output logic [7:0]                   repeat_res,
    output logic [1:0]                   status,
    output logic [COUNT_BITS-1:0]        total_emitted,
    output logic                         last_of_run,
    input  logic                         cfg_we,
    input  logic [tdsd_pkg::LIMIT_W-1:0] cfg_wdata
);
    import tdsd_pkg::*;

    step_t                 step;
    logic [COUNT_BITS-1:0] total;
    logic                  accept;
    logic                  pop;

    logic                  val_v_reg;
    logic                  end_v_reg;
    logic [31:0]           val_reg;
    logic [7:0]            rep_reg;
    logic [1:0]            st_reg;
    logic [COUNT_BITS-1:0] total_reg;

    tdsd_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .end_of_buffer(end_of_buffer),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .step         (step),
        .total        (total)
    );

    assign out_valid = val_v_reg | end_v_reg;
    assign pop       = out_valid & out_ready;
    // The slots hold at most one byte's results; take the next byte once the
    // last of them goes out.
    assign in_ready  = !out_valid || (out_ready && (val_v_reg ^ end_v_reg));
    assign accept    = in_valid & in_ready;

    assign kind          = val_v_reg ? KIND_VALUE : KIND_STATUS;
    assign value         = val_v_reg ? val_reg : 32'sd0;
    assign repeat_res    = val_v_reg ? rep_reg : 8'd0;
    assign status        = val_v_reg ? ST_OK : st_reg;
    assign total_emitted = total_reg;
    assign last_of_run   = val_v_reg ? !end_v_reg : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            val_v_reg <= 1'b0;
            end_v_reg <= 1'b0;
        end else if (accept) begin
            val_v_reg <= step.val_v;
            end_v_reg <= step.end_v;
        end else if (pop) begin
            if (val_v_reg)
                val_v_reg <= 1'b0;
            else
                end_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            val_reg   <= step.val;
            rep_reg   <= step.rep;
            st_reg    <= step.st;
            total_reg <= total;
        end
    end

endmodule

@@ tb/sv/tdsd_decode_checker.sv @@
// ----------------------------------------------------------------------------
// Tagged delta stream decoder checker
// Watches the byte and result channels, predicts the result beats of every
// accepted byte and compares each accepted result beat, field by field, with
// the oldest prediction. It tracks the count limit from the config port.
// ----------------------------------------------------------------------------
module tdsd_decode_checker #(
    parameter int COUNT_BITS = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         end_of_buffer,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         kind,
    input  logic signed [31:0]           value,
    input  logic [7:0]                   repeat_res,
    input  logic [1:0]                   status,
    input  logic [COUNT_BITS-1:0]        total_emitted,
    input  logic                         last_of_run,
    input  logic                         cfg_we,
    input  logic [tdsd_pkg::LIMIT_W-1:0] cfg_wdata,
    output int                           mismatches,
    output int                           pending
);

    import tdsd_pkg::*;

    // "IDLT" as it arrives, first byte in the low bits.
    localparam logic [31:0] ID_MAGIC = 32'h544C_4449;

    typedef struct packed {
        logic                  kind;
        logic [31:0]           value;
        logic [7:0]            repeat_n;
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] total;
        logic                  last;
    } beat_t;

    logic [3:0]            hdr_pos;
    logic                  magic_bad;
    logic [31:0]           declared;
    logic [31:0]           acc;
    logic [COUNT_BITS-1:0] emitted;
    logic [2:0]            phase;
    logic [1:0]            opnd_idx;
    logic [31:0]           opnd;
    logic [LIMIT_W-1:0]    limit;
    beat_t                 expected_beats[$];
    int                    beats_seen;
    int                    produced;
    int                    err_count = 0;

    task automatic report(input string msg);
        $display("%0t: mismatch at result beat %0d: %s", $time, beats_seen, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic clear_message();
        hdr_pos   = '0;
        magic_bad = 1'b0;
        declared  = '0;
        acc       = '0;
        emitted   = '0;
        phase     = PH_HEADER;
        opnd_idx  = '0;
        opnd      = '0;
    endtask

    // Emit up to run copies of the accumulator, never past the declared count.
    task automatic emit_values(input logic [31:0] run);
        logic [31:0] left;
        logic [31:0] rep;
        beat_t       bt;
        left = declared - 32'(emitted);
        rep  = (run < left) ? run : left;
        if (rep != 0) begin
            emitted     = emitted + COUNT_BITS'(rep);
            bt.kind     = KIND_VALUE;
            bt.value    = acc;
            bt.repeat_n = rep[7:0];
            bt.status   = ST_OK;
            bt.total    = emitted;
            bt.last     = 1'b0;
            expected_beats.push_back(bt);
            produced++;
            phase = (32'(emitted) >= declared) ? PH_STOP : PH_TAG;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eob);
        beat_t bt;
        produced = 0;
        case (phase)
            PH_HEADER: begin
                if (hdr_pos < MAGIC_LEN) begin
                    if (b != ID_MAGIC[8*hdr_pos +: 8])
                        magic_bad = 1'b1;
                end else if (hdr_pos >= COUNT_POS) begin
                    declared[8*(hdr_pos - COUNT_POS) +: 8] = b;
                end
                hdr_pos = hdr_pos + 4'd1;
                if (hdr_pos >= HEADER_LEN) begin
                    if (magic_bad)
                        phase = PH_BADMAGIC;
                    else if (declared > 32'(limit))
                        phase = PH_LIMIT;
                    else if (declared == 0)
                        phase = PH_STOP;
                    else
                        phase = PH_TAG;
                end
            end
            PH_TAG: begin
                opnd_idx = '0;
                opnd     = '0;
                case (b)
                    TAG_LOAD:  phase = PH_LOAD;
                    TAG_DELTA: phase = PH_DELTA;
                    TAG_RUN:   phase = PH_RUN;
                    TAG_CLEAR: acc = '0;
                    default:   phase = PH_STOP;
                endcase
            end
            PH_LOAD, PH_DELTA: begin
                opnd[8*opnd_idx +: 8] = b;
                opnd_idx = opnd_idx + 2'd1;
                if (phase == PH_LOAD && opnd_idx == 2'd0) begin
                    acc = opnd;
                    emit_values(32'd1);
                end else if (phase == PH_DELTA && opnd_idx == 2'd2) begin
                    acc = acc + {{16{opnd[15]}}, opnd[15:0]};
                    emit_values(32'd1);
                end
            end
            PH_RUN: begin
                emit_values(32'(b));
                // A zero run leaves the phase alone; the next byte is a tag.
                if (phase == PH_RUN)
                    phase = PH_TAG;
            end
            default: ;
        endcase

        if (eob) begin
            bt.kind     = KIND_STATUS;
            bt.value    = '0;
            bt.repeat_n = '0;
            if (phase == PH_HEADER || phase == PH_BADMAGIC)
                bt.status = ST_HEADER;
            else if (phase == PH_LIMIT)
                bt.status = ST_LIMIT;
            else
                bt.status = ST_OK;
            bt.total = emitted;
            bt.last  = 1'b0;
            expected_beats.push_back(bt);
            produced++;
            clear_message();
        end

        if (produced > 0) begin
            bt      = expected_beats.pop_back();
            bt.last = 1'b1;
            expected_beats.push_back(bt);
        end
    endtask

    task automatic check_beat();
        beat_t want;
        beats_seen++;
        if (expected_beats.size() == 0) begin
            report($sformatf("unexpected beat kind %0d value %0h repeat %0d status %0d total %0d",
                             kind, value, repeat_res, status, total_emitted));
        end else begin
            want = expected_beats.pop_front();
            check_field("kind", kind, want.kind);
            check_field("value", value, want.value);
            check_field("repeat_res", repeat_res, want.repeat_n);
            check_field("status", status, want.status);
            check_field("total_emitted", total_emitted, want.total);
            check_field("last_of_run", last_of_run, want.last);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_message();
            limit = LIMIT_RESET;
            expected_beats.delete();
            beats_seen = 0;
            err_count  = 0;
            pending    <= 0;
            mismatches <= 0;
        end else begin
            if (cfg_we)
                limit = cfg_wdata;
            if (in_valid && in_ready)
                decode_byte(data_byte, end_of_buffer);
            if (out_valid && out_ready)
                check_beat();
            pending    <= expected_beats.size();
            mismatches <= err_count;
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Tagged delta stream decoder testbench
// Feeds directed and random messages through the decoder under several count
// limits, with random gaps and stalls on both channels, a long output
// hold-off and drained pauses, and leaves the checking to the checker module.
// ----------------------------------------------------------------------------
module testbench;

    import tdsd_pkg::*;

    localparam int COUNT_BITS  = 20;
    localparam int HALF_PERIOD = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 180;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_IDLE    = 17;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_ready;
    logic [7:0]            data_byte     = 8'd0;
    logic                  end_of_buffer = 1'b0;
    logic                  out_valid;
    logic                  out_ready     = 1'b0;
    logic                  kind;
    logic signed [31:0]    value;
    logic [7:0]            repeat_res;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] total_emitted;
    logic                  last_of_run;
    logic                  cfg_we        = 1'b0;
    logic [LIMIT_W-1:0]    cfg_wdata     = '0;

    int                 mismatches;
    int                 pending;
    int                 cycle_count   = 0;
    int                 sent_in_phase = 0;
    int                 send_calm     = 0;
    int                 recv_calm     = 0;
    bit                 hold_off_req  = 1'b0;
    logic [LIMIT_W-1:0] cur_limit     = LIMIT_RESET;
    logic [8:0]         msg_bytes[$];

    always #(HALF_PERIOD) clk = ~clk;

    tagged_delta_stream_decoder #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_buffer(end_of_buffer),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .value        (value),
        .repeat_res   (repeat_res),
        .status       (status),
        .total_emitted(total_emitted),
        .last_of_run  (last_of_run),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    tdsd_decode_checker #(
        .COUNT_BITS(COUNT_BITS)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_buffer(end_of_buffer),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .value        (value),
        .repeat_res   (repeat_res),
        .status       (status),
        .total_emitted(total_emitted),
        .last_of_run  (last_of_run),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL tagged_delta_stream_decoder");
            $finish;
        end
    end

    // Idle cycles before the next beat, with occasional stretches of none.
    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, MAX_IDLE);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        msg_bytes.push_back({1'b0, b});
    endtask

    task automatic add_header(input logic [31:0] count, input bit bad_magic);
        int         bad_at;
        logic [7:0] m;
        bad_at = bad_magic ? $urandom_range(0, 3) : -1;
        for (int i = 0; i < 4; i++) begin
            m = magic_byte(2'(i));
            if (i == bad_at)
                m = m ^ 8'($urandom_range(1, 255));
            push_byte(m);
        end
        for (int i = 0; i < 4; i++)
            push_byte(8'($urandom));
        for (int i = 0; i < 4; i++)
            push_byte(count[8*i +: 8]);
    endtask

    task automatic add_record();
        int          pick;
        int          sel;
        logic [31:0] v;
        pick = $urandom_range(0, 99);
        v    = $urandom;
        sel  = $urandom_range(0, 9);
        if (pick < 28) begin
            if (sel == 0)
                v = 32'h8000_0000;
            else if (sel == 1)
                v = 32'h7FFF_FFFF;
            push_byte(TAG_LOAD);
            for (int i = 0; i < 4; i++)
                push_byte(v[8*i +: 8]);
        end else if (pick < 56) begin
            if (sel == 0)
                v[15:0] = 16'h8000;
            else if (sel == 1)
                v[15:0] = 16'h7FFF;
            push_byte(TAG_DELTA);
            push_byte(v[7:0]);
            push_byte(v[15:8]);
        end else if (pick < 84) begin
            push_byte(TAG_RUN);
            if (sel == 0)
                push_byte(8'd0);
            else if (sel == 1)
                push_byte(8'hFF);
            else
                push_byte(8'($urandom_range(1, 6)));
        end else if (pick < 95) begin
            push_byte(TAG_CLEAR);
        end else begin
            push_byte(8'($urandom_range(4, 255)));
        end
    endtask

    // A record cut short by the end of the message.
    task automatic add_partial_record();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
            push_byte(TAG_LOAD);
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
        end else if (pick == 1) begin
            push_byte(TAG_DELTA);
            repeat ($urandom_range(0, 1)) push_byte(8'($urandom));
        end else begin
            push_byte(TAG_RUN);
        end
    endtask

    task automatic build_message();
        int          pick;
        int          ending;
        int          cap;
        logic [31:0] count;
        logic [8:0]  tail;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            // Header cut short somewhere in its first eleven bytes.
            add_header(32'($urandom_range(1, 20)), 1'b0);
            repeat (12 - $urandom_range(1, 11)) void'(msg_bytes.pop_back());
        end else if (pick < 10) begin
            add_header(32'($urandom_range(1, 20)), 1'b1);
            repeat ($urandom_range(0, 3)) add_record();
        end else if (pick < 15) begin
            if (cur_limit == LIMIT_MAX)
                count = $urandom_range(32'h0010_0000, 32'hFFFF_FFFF);
            else if ($urandom_range(0, 1) == 0)
                count = 32'(cur_limit) + 32'd1;
            else
                count = $urandom_range(32'(cur_limit) + 32'd1, 32'hFFFF_FFFF);
            add_header(count, 1'b0);
            repeat ($urandom_range(0, 3)) add_record();
        end else begin
            cap = (cur_limit < 40) ? int'(cur_limit) : 40;
            if (pick < 19 || cur_limit == 0)
                count = 32'd0;
            else if (pick < 25 && cur_limit <= 64)
                count = 32'(cur_limit);
            else
                count = $urandom_range(1, cap);
            add_header(count, 1'b0);
            repeat ($urandom_range(0, 12)) add_record();
            ending = $urandom_range(0, 9);
            if (ending < 2)
                add_partial_record();
            else if (ending < 4)
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        end
        tail = msg_bytes.pop_back();
        msg_bytes.push_back({1'b1, tail[7:0]});
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eob);
        int gap;
        gap = draw_idle(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_buffer <= eob;
        do @(posedge clk); while (!in_ready);
        sent_in_phase++;
    endtask

    task automatic send_message();
        logic [8:0] mb;
        while (msg_bytes.size() > 0) begin
            mb = msg_bytes.pop_front();
            send_byte(mb[7:0], mb[8]);
        end
    endtask

    // Stop sending and wait until every predicted beat has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase();
        sent_in_phase = 0;
        while (sent_in_phase < PHASE_BYTES) begin
            build_message();
            send_message();
        end
        drain_results();
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit = v;
    endtask

    initial begin : receiver
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = draw_idle(recv_calm);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial begin : stimulus
        logic [LIMIT_W-1:0] limits[5];
        limits[0] = '0;
        limits[1] = LIMIT_MAX;
        limits[2] = 20'd12;
        limits[3] = LIMIT_W'($urandom_range(2, 1048574));
        limits[4] = 20'd1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A header cut off after its first byte.
        msg_bytes.push_back({1'b1, magic_byte(2'd0)});
        // Count of three: load the most negative value, step by minus one to
        // the most positive, clear, a zero run, then a long run cut to the
        // one value left, ending on the run byte so two beats come out.
        add_header(32'd3, 1'b0);
        push_byte(TAG_LOAD);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h80);
        push_byte(TAG_DELTA);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(TAG_CLEAR);
        push_byte(TAG_RUN);
        push_byte(8'h00);
        push_byte(TAG_RUN);
        msg_bytes.push_back({1'b1, 8'hFF});
        send_message();

        run_phase();
        for (int i = 0; i < 5; i++) begin
            write_limit(limits[i]);
            // Under the widest limit the output side also stops for a while.
            if (i == 1)
                hold_off_req = 1'b1;
            run_phase();
        end

        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("PASS tagged_delta_stream_decoder");
        else
            $display("FAIL tagged_delta_stream_decoder");
        $finish;
    end

endmodule
